// File: rtl/core/hwc_pkg.sv
// Shared types and constants for the hue wheel color generator.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package hwc_pkg;

    localparam int HUE_W        = 16;
    localparam int CHAN_W       = 8;
    localparam int COLOR_W      = 3 * CHAN_W;
    localparam int LEVEL_W      = HUE_W + 1;          // full level is 2^16
    localparam int SECTOR_W     = 3;
    localparam int SCALED_W     = HUE_W + SECTOR_W;   // hue * 6
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [LEVEL_W-1:0]  FULL_LEVEL   = LEVEL_W'(1) << HUE_W;
    localparam logic [SECTOR_W-1:0] SECTOR_COUNT = 3'd6;

    localparam logic [HUE_W-1:0]  HUE_STEP_RESET   = 16'd10;
    localparam logic [CHAN_W-1:0] BRIGHTNESS_RESET = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HUE_STEP   = 1'b0,
        CFG_BRIGHTNESS = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_CONVERT = 1'b1
    } opcode_t;

    // One input word as it moves into the hue stage.
    typedef struct packed {
        logic             accept;
        opcode_t          opcode;
        logic [HUE_W-1:0] hue;
    } item_t;

    typedef enum logic [SECTOR_W-1:0] {
        SEC_RED_GREEN   = 3'd0,
        SEC_GREEN_RED   = 3'd1,
        SEC_GREEN_BLUE  = 3'd2,
        SEC_BLUE_GREEN  = 3'd3,
        SEC_BLUE_RED    = 3'd4,
        SEC_RED_BLUE    = 3'd5
    } sector_t;

    // floor(level * brightness / 65536); the result never exceeds brightness.
    function automatic logic [CHAN_W-1:0] scale_level(
        input logic [LEVEL_W-1:0] level,
        input logic [CHAN_W-1:0]  brightness
    );
        logic [LEVEL_W+CHAN_W-1:0] prod;
        prod = (LEVEL_W+CHAN_W)'(level) * (LEVEL_W+CHAN_W)'(brightness);
        return prod[HUE_W +: CHAN_W];
    endfunction

endpackage

// File: rtl/core/hue_wheel_color_generator_unit.sv
// Hue wheel color generator: turns a 16-bit hue into a saturated 24-bit GRB LED color.
// Depends on hwc_pkg, hwc_hue_stage and hwc_color_conv.
//
// Each accepted word gives exactly one color word. An advance word (opcode 0) converts
// the stored hue and then adds hue_step to it, wrapping at 2^16; a convert word
// (opcode 1) converts hue_in and leaves the stored hue alone. The hue is split into six
// sectors of hue*6; one channel is full, one ramps and one is off, and each is scaled
// so a full channel reads as brightness. The block takes one word per clock while
// the pipeline is not stalled; an accepted word is held in the hue register (where
// the stored hue is read and stepped) and then passes through the conversion logic
// into the color output register. A stalled color waits in the output register
// while the hue register may still take one more word; once both hold a word, a
// stall on the color side drops item_ready in the same cycle, since item_ready
// follows color_ready combinationally. Registers are
// written through cfg_we/cfg_index/cfg_data (index 0 hue_step, index 1 brightness,
// data taken from the low bits); write them only while no word is in flight.
module hue_wheel_color_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [hwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hwc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input words
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              opcode,
    input  logic [hwc_pkg::HUE_W-1:0]         hue_in,
    // color words
    output logic                              color_valid,
    input  logic                              color_ready,
    output logic [hwc_pkg::COLOR_W-1:0]       grb_color
);

    logic [hwc_pkg::HUE_W-1:0]   hue_step_reg;
    logic [hwc_pkg::HUE_W-1:0]   hue_step_next;
    logic [hwc_pkg::CHAN_W-1:0]  brightness_reg;
    logic [hwc_pkg::CHAN_W-1:0]  brightness_next;

    logic                        hue_valid_reg;
    logic                        hue_valid_next;
    logic                        color_valid_reg;
    logic                        color_valid_next;
    logic [hwc_pkg::COLOR_W-1:0] grb_reg;
    logic [hwc_pkg::COLOR_W-1:0] grb_next;

    logic                        item_accept;
    logic                        color_load;
    hwc_pkg::item_t              item;
    logic [hwc_pkg::HUE_W-1:0]   stage_hue;
    logic [hwc_pkg::COLOR_W-1:0] conv_grb;

    // ---- configuration registers ----
    always_comb
    begin
        hue_step_next   = hue_step_reg;
        brightness_next = brightness_reg;
        if (cfg_we)
        begin
            case (hwc_pkg::cfg_index_t'(cfg_index))
                hwc_pkg::CFG_HUE_STEP:   hue_step_next   = cfg_data;
                hwc_pkg::CFG_BRIGHTNESS: brightness_next = cfg_data[hwc_pkg::CHAN_W-1:0];
                default:                 hue_step_next   = hue_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_step_reg   <= hwc_pkg::HUE_STEP_RESET;
            brightness_reg <= hwc_pkg::BRIGHTNESS_RESET;
        end
        else
        begin
            hue_step_reg   <= hue_step_next;
            brightness_reg <= brightness_next;
        end
    end

    // ---- pipeline control ----
    // color register takes the held hue word when it is empty or its word leaves this cycle
    assign color_load  = hue_valid_reg && (!color_valid_reg || color_ready);
    assign item_ready  = !hue_valid_reg || color_load;
    assign item_accept = item_valid && item_ready;

    assign item = '{accept: item_accept,
                    opcode: hwc_pkg::opcode_t'(opcode),
                    hue:    hue_in};

    always_comb
    begin
        hue_valid_next = hue_valid_reg;
        if (item_accept)
        begin
            hue_valid_next = 1'b1;
        end
        else if (color_load)
        begin
            hue_valid_next = 1'b0;
        end

        color_valid_next = color_valid_reg;
        grb_next         = grb_reg;
        if (color_load)
        begin
            color_valid_next = 1'b1;
            grb_next         = conv_grb;
        end
        else if (color_ready)
        begin
            color_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_valid_reg   <= 1'b0;
            color_valid_reg <= 1'b0;
        end
        else
        begin
            hue_valid_reg   <= hue_valid_next;
            color_valid_reg <= color_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grb_reg <= grb_next;
    end

    // ---- datapath ----
    hwc_hue_stage u_hue_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .hue_step (hue_step_reg),
        .hue      (stage_hue)
    );

    hwc_color_conv u_color_conv (
        .hue        (stage_hue),
        .brightness (brightness_reg),
        .grb        (conv_grb)
    );

    assign color_valid = color_valid_reg;
    assign grb_color   = grb_reg;

    // ---- checks ----
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        color_load |=> color_valid_reg)
        else $error("converted word did not reach the color register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> hue_valid_reg && color_valid_reg && !color_ready)
        else $error("input stalled while the pipeline had room");

    a_hue_word_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        hue_valid_reg && !color_load |=> hue_valid_reg && $stable(stage_hue))
        else $error("held hue word was dropped or changed");

    a_color_held: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid_reg && !color_ready |=> color_valid_reg && $stable(grb_reg))
        else $error("stalled color word was dropped or changed");

endmodule

// File: rtl/core/hwc_hue_stage.sv
// Input stage: holds the hue accumulator and registers the hue of each accepted word.
// Depends on hwc_pkg.
module hwc_hue_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hwc_pkg::item_t            item,
    input  logic [hwc_pkg::HUE_W-1:0] hue_step,
    output logic [hwc_pkg::HUE_W-1:0] hue
);

    logic [hwc_pkg::HUE_W-1:0] acc_reg;
    logic [hwc_pkg::HUE_W-1:0] acc_next;
    logic [hwc_pkg::HUE_W-1:0] hue_reg;
    logic [hwc_pkg::HUE_W-1:0] hue_next;

    always_comb
    begin
        acc_next = acc_reg;
        hue_next = hue_reg;
        if (item.accept)
        begin
            case (item.opcode)
                hwc_pkg::OP_ADVANCE:
                begin
                    hue_next = acc_reg;
                    acc_next = acc_reg + hue_step;   // wraps mod 2^16
                end
                hwc_pkg::OP_CONVERT:
                begin
                    hue_next = item.hue;
                end
                default:
                begin
                    hue_next = item.hue;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= hue_next;
    end

    assign hue = hue_reg;

    a_convert_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        item.accept && item.opcode == hwc_pkg::OP_CONVERT |=> $stable(acc_reg))
        else $error("convert word changed the hue accumulator");

    a_advance_steps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        item.accept && item.opcode == hwc_pkg::OP_ADVANCE |=>
            acc_reg == hwc_pkg::HUE_W'($past(acc_reg) + $past(hue_step)))
        else $error("advance word did not step the hue accumulator");

    a_advance_uses_acc: assert property (@(posedge clk) disable iff (!rst_n)
        item.accept && item.opcode == hwc_pkg::OP_ADVANCE |=> hue_reg == $past(acc_reg))
        else $error("advance word did not latch the stored hue");

endmodule

// File: rtl/core/hwc_color_conv.sv
// Combinational hue to GRB conversion: sector/fraction split, ramp, brightness scaling.
// Depends on hwc_pkg.
module hwc_color_conv (
    input  logic [hwc_pkg::HUE_W-1:0]   hue,
    input  logic [hwc_pkg::CHAN_W-1:0]  brightness,
    output logic [hwc_pkg::COLOR_W-1:0] grb
);

    logic [hwc_pkg::SCALED_W-1:0] scaled;
    logic [hwc_pkg::SECTOR_W-1:0] sector;
    logic [hwc_pkg::HUE_W-1:0]    frac;
    logic [hwc_pkg::LEVEL_W-1:0]  ramp;
    logic [hwc_pkg::LEVEL_W-1:0]  lvl_r;
    logic [hwc_pkg::LEVEL_W-1:0]  lvl_g;
    logic [hwc_pkg::LEVEL_W-1:0]  lvl_b;

    // hue * 6 as shift-add
    assign scaled = (hwc_pkg::SCALED_W'(hue) << 2) + (hwc_pkg::SCALED_W'(hue) << 1);
    assign sector = scaled[hwc_pkg::SCALED_W-1 -: hwc_pkg::SECTOR_W];
    assign frac   = scaled[hwc_pkg::HUE_W-1:0];
    // odd sectors ramp down; zero fraction there gives full level
    assign ramp   = sector[0] ? (hwc_pkg::FULL_LEVEL - hwc_pkg::LEVEL_W'(frac))
                              : hwc_pkg::LEVEL_W'(frac);

    always_comb
    begin
        case (sector)
            hwc_pkg::SEC_RED_GREEN:
            begin
                lvl_r = hwc_pkg::FULL_LEVEL; lvl_g = ramp; lvl_b = '0;
            end
            hwc_pkg::SEC_GREEN_RED:
            begin
                lvl_r = ramp; lvl_g = hwc_pkg::FULL_LEVEL; lvl_b = '0;
            end
            hwc_pkg::SEC_GREEN_BLUE:
            begin
                lvl_r = '0; lvl_g = hwc_pkg::FULL_LEVEL; lvl_b = ramp;
            end
            hwc_pkg::SEC_BLUE_GREEN:
            begin
                lvl_r = '0; lvl_g = ramp; lvl_b = hwc_pkg::FULL_LEVEL;
            end
            hwc_pkg::SEC_BLUE_RED:
            begin
                lvl_r = ramp; lvl_g = '0; lvl_b = hwc_pkg::FULL_LEVEL;
            end
            default:
            begin
                lvl_r = hwc_pkg::FULL_LEVEL; lvl_g = '0; lvl_b = ramp;
            end
        endcase
    end

    assign grb = {hwc_pkg::scale_level(lvl_g, brightness),
                  hwc_pkg::scale_level(lvl_r, brightness),
                  hwc_pkg::scale_level(lvl_b, brightness)};

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for hue_wheel_color_generator_unit.
// Needs hwc_pkg and the block's RTL; drives directed rows, then random words across
// several register settings, and checks every color word against a local color model or a hand-typed color.
module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 125;   // six random phases, about 750 words
    localparam int TAIL_CYCLES   = 8;
    localparam int SETTLE_CYCLES = 4;

    // ------------------------------------------------------------------
    // Clock and block ports
    // ------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [hwc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [hwc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            item_valid;
    logic                            item_ready;
    logic                            opcode;
    logic [hwc_pkg::HUE_W-1:0]       hue_in;
    logic                            color_valid;
    logic                            color_ready = 1'b0;
    logic [hwc_pkg::COLOR_W-1:0]     grb_color;

    always #10 clk = ~clk;

    hue_wheel_color_generator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .opcode      (opcode),
        .hue_in      (hue_in),
        .color_valid (color_valid),
        .color_ready (color_ready),
        .grb_color   (grb_color)
    );

    // ------------------------------------------------------------------
    // Color model: its own copy of the stored hue and both registers
    // ------------------------------------------------------------------
    logic [hwc_pkg::HUE_W-1:0]   model_hue    = '0;
    logic [hwc_pkg::HUE_W-1:0]   model_step   = hwc_pkg::HUE_STEP_RESET;
    logic [hwc_pkg::CHAN_W-1:0]  model_bright = hwc_pkg::BRIGHTNESS_RESET;
    logic [hwc_pkg::COLOR_W-1:0] pending_colors[$];   // colors still owed by the block
    int                          fail_count   = 0;
    int                          cycle_count  = 0;

    // Sideband for directed rows whose color is typed in by hand.
    logic                        word_known   = 1'b0;
    logic [hwc_pkg::COLOR_W-1:0] word_color   = '0;

    // floor(level * brightness / 2^16); level runs up to 2^16 inclusive
    function automatic logic [hwc_pkg::CHAN_W-1:0] level_to_chan(
        input logic [hwc_pkg::LEVEL_W-1:0] level,
        input logic [hwc_pkg::CHAN_W-1:0]  bright
    );
        logic [hwc_pkg::LEVEL_W+hwc_pkg::CHAN_W-1:0] prod;
        prod = (hwc_pkg::LEVEL_W+hwc_pkg::CHAN_W)'(level)
             * (hwc_pkg::LEVEL_W+hwc_pkg::CHAN_W)'(bright);
        return prod[hwc_pkg::HUE_W +: hwc_pkg::CHAN_W];
    endfunction

    function automatic logic [hwc_pkg::COLOR_W-1:0] wheel_grb(
        input logic [hwc_pkg::HUE_W-1:0]  hue,
        input logic [hwc_pkg::CHAN_W-1:0] bright
    );
        logic [hwc_pkg::SCALED_W-1:0] scaled;
        logic [hwc_pkg::LEVEL_W-1:0]  ramp;
        logic [hwc_pkg::LEVEL_W-1:0]  r, g, b;
        hwc_pkg::sector_t             sector;
        scaled = hwc_pkg::SCALED_W'(hue) * hwc_pkg::SCALED_W'(hwc_pkg::SECTOR_COUNT);
        sector = hwc_pkg::sector_t'(scaled[hwc_pkg::SCALED_W-1:hwc_pkg::HUE_W]);
        // odd sectors ramp down; zero fraction there means a full channel
        ramp   = scaled[hwc_pkg::HUE_W]
               ? (hwc_pkg::FULL_LEVEL - hwc_pkg::LEVEL_W'(scaled[hwc_pkg::HUE_W-1:0]))
               : hwc_pkg::LEVEL_W'(scaled[hwc_pkg::HUE_W-1:0]);
        case (sector)
            hwc_pkg::SEC_RED_GREEN:
            begin
                r = hwc_pkg::FULL_LEVEL; g = ramp; b = '0;
            end
            hwc_pkg::SEC_GREEN_RED:
            begin
                r = ramp; g = hwc_pkg::FULL_LEVEL; b = '0;
            end
            hwc_pkg::SEC_GREEN_BLUE:
            begin
                r = '0; g = hwc_pkg::FULL_LEVEL; b = ramp;
            end
            hwc_pkg::SEC_BLUE_GREEN:
            begin
                r = '0; g = ramp; b = hwc_pkg::FULL_LEVEL;
            end
            hwc_pkg::SEC_BLUE_RED:
            begin
                r = ramp; g = '0; b = hwc_pkg::FULL_LEVEL;
            end
            default:
            begin
                r = hwc_pkg::FULL_LEVEL; g = '0; b = ramp;
            end
        endcase
        return {level_to_chan(g, bright), level_to_chan(r, bright), level_to_chan(b, bright)};
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check the color side first, then book the accepted input word.
    // Both handshakes are sampled at the rising edge; inputs only move on the
    // falling edge, so nothing here races the block.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && color_valid && color_ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("grb_color: unexpected word %h with nothing owed", grb_color);
                fail_count++;
            end
            else
            begin
                if (grb_color !== pending_colors[0])
                begin
                    $error("grb_color expected %h actual %h", pending_colors[0], grb_color);
                    fail_count++;
                end
                void'(pending_colors.pop_front());
            end
        end
        if (rst_n && item_valid && item_ready)
        begin
            if (opcode == hwc_pkg::OP_ADVANCE)
            begin
                pending_colors.push_back(word_known ? word_color
                                                    : wheel_grb(model_hue, model_bright));
                model_hue = model_hue + model_step;   // wraps at 2^16
            end
            else
            begin
                pending_colors.push_back(word_known ? word_color
                                                    : wheel_grb(hue_in, model_bright));
            end
        end
    end

    // ------------------------------------------------------------------
    // Color side back-pressure: a 16-bit ready pattern, rotated each cycle and
    // re-drawn every so often. Some patterns are all ones (no stalls at all);
    // bit 0 is forced on in the others so the pattern never locks up.
    // ------------------------------------------------------------------
    logic [15:0] stall_pattern = '1;
    int unsigned pattern_age   = 0;

    always @(negedge clk)
    begin
        if (pattern_age == 0)
        begin
            pattern_age <= $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0:       stall_pattern <= '1;
                1:       stall_pattern <= 16'($urandom) | 16'h0001;
                default: stall_pattern <= 16'($urandom | $urandom) | 16'h0001;
            endcase
        end
        else
        begin
            pattern_age   <= pattern_age - 1;
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
        color_ready <= stall_pattern[0];
    end

    // ------------------------------------------------------------------
    // Input side: words go out in bursts of random length with random gaps.
    // All tasks are entered and left on a falling edge.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_word(input hwc_pkg::opcode_t op,
                             input logic [hwc_pkg::HUE_W-1:0] hue,
                             input logic known,
                             input logic [hwc_pkg::COLOR_W-1:0] color);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        item_valid <= 1'b1;
        opcode     <= op;
        hue_in     <= hue;
        word_known <= known;
        word_color <= color;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    // Drain: no word in flight before a register changes.
    task automatic wait_idle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (pending_colors.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input hwc_pkg::cfg_index_t idx,
                             input logic [hwc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == hwc_pkg::CFG_HUE_STEP)
            model_step = data;
        else
            model_bright = data[hwc_pkg::CHAN_W-1:0];   // upper data bits are dropped
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly random hues, with the ends of the range, the half-turn point and
    // the six sector edges (one either side) mixed in.
    function automatic logic [hwc_pkg::HUE_W-1:0] pick_hue();
        int k;
        k = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3, 4:    return 16'((k * 65536) / 6 + $urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed rows: either a word or a register write
    // ------------------------------------------------------------------
    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic                        sel;      // opcode for a word, index for a write
        logic [hwc_pkg::HUE_W-1:0]   value;    // hue_in or write data
        logic                        known;    // color typed in below
        logic [hwc_pkg::COLOR_W-1:0] color;
    } stim_row_t;

    stim_row_t dir_rows[$];

    task automatic add_word(input hwc_pkg::opcode_t op, input logic [hwc_pkg::HUE_W-1:0] hue);
        dir_rows.push_back('{ROW_WORD, op, hue, 1'b0, '0});
    endtask

    task automatic add_known(input hwc_pkg::opcode_t op,
                             input logic [hwc_pkg::HUE_W-1:0] hue,
                             input logic [hwc_pkg::COLOR_W-1:0] color);
        dir_rows.push_back('{ROW_WORD, op, hue, 1'b1, color});
    endtask

    task automatic add_cfg(input hwc_pkg::cfg_index_t idx,
                           input logic [hwc_pkg::CFG_DATA_W-1:0] data);
        dir_rows.push_back('{ROW_CFG, idx, data, 1'b0, '0});
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t                      row;
        logic [hwc_pkg::CFG_DATA_W-1:0] phase_step;
        logic [hwc_pkg::CHAN_W-1:0]     phase_bright;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = hwc_pkg::CFG_HUE_STEP;
        cfg_data   = '0;
        item_valid = 1'b0;
        opcode     = hwc_pkg::OP_ADVANCE;
        hue_in     = '0;

        // Reset values first: step 10, brightness 255, stored hue 0.
        add_known(hwc_pkg::OP_CONVERT, 16'h0000, 24'h00FF00);   // pure red
        add_known(hwc_pkg::OP_ADVANCE, 16'h1234, 24'h00FF00);   // stored hue 0
        add_word (hwc_pkg::OP_ADVANCE, 16'hFFFF);               // stored hue 10
        add_known(hwc_pkg::OP_CONVERT, 16'h8000, 24'hFF00FF);   // odd sector, zero fraction
        add_word (hwc_pkg::OP_CONVERT, 16'hFFFF);
        // middle of each of the six sectors
        add_word (hwc_pkg::OP_CONVERT, 16'd5461);
        add_word (hwc_pkg::OP_CONVERT, 16'd16384);
        add_word (hwc_pkg::OP_CONVERT, 16'd27307);
        add_word (hwc_pkg::OP_CONVERT, 16'd38229);
        add_word (hwc_pkg::OP_CONVERT, 16'd49152);
        add_word (hwc_pkg::OP_CONVERT, 16'd60075);
        // largest step: every advance wraps
        add_cfg  (hwc_pkg::CFG_HUE_STEP, 16'hFFFF);
        add_word (hwc_pkg::OP_ADVANCE, 16'h0000);
        add_word (hwc_pkg::OP_ADVANCE, 16'hFFFF);
        // brightness zero blanks everything; junk in the upper data byte
        add_cfg  (hwc_pkg::CFG_BRIGHTNESS, 16'hA500);
        add_known(hwc_pkg::OP_CONVERT, 16'h8000, 24'h000000);
        add_known(hwc_pkg::OP_ADVANCE, 16'h0000, 24'h000000);
        add_cfg  (hwc_pkg::CFG_BRIGHTNESS, 16'h5A01);
        add_word (hwc_pkg::OP_CONVERT, 16'hFFFF);
        // zero step: stored hue holds
        add_cfg  (hwc_pkg::CFG_HUE_STEP, 16'h0000);
        add_word (hwc_pkg::OP_ADVANCE, 16'h0000);
        add_word (hwc_pkg::OP_ADVANCE, 16'h0000);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(hwc_pkg::cfg_index_t'(row.sel), row.value);
            end
            else
            begin
                send_word(hwc_pkg::opcode_t'(row.sel), row.value, row.known, row.color);
            end
        end

        // Random phases: three fixed settings first, then random settings.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    phase_step = 16'hFFFF; phase_bright = 8'd255;
                end
                1:
                begin
                    phase_step = 16'h0000; phase_bright = 8'd0;
                end
                2:
                begin
                    phase_step = 16'h0001; phase_bright = 8'd128;
                end
                default:
                begin
                    phase_step   = 16'($urandom);
                    phase_bright = 8'($urandom_range(0, 255));
                end
            endcase
            wait_idle();
            write_reg(hwc_pkg::CFG_HUE_STEP, phase_step);
            write_reg(hwc_pkg::CFG_BRIGHTNESS, {8'($urandom), phase_bright});
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(hwc_pkg::opcode_t'($urandom_range(0, 1)), pick_hue(), 1'b0, '0);
        end

        item_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/hwc_pkg.sv
rtl/core/hwc_hue_stage.sv
rtl/core/hwc_color_conv.sv
rtl/core/hue_wheel_color_generator_unit.sv
tb/tb_top.sv
